@@ rtl/b2d_pkg.sv @@
package b2d_pkg;

    // Sizes of the conversion
    localparam int DIGIT_COUNT = 40;
    localparam int VALUE_W     = 128;
    localparam int HALF_W      = 64;
    localparam int NIBBLE_W    = 4;
    localparam int BCD_W       = DIGIT_COUNT * NIBBLE_W;
    // 2^127-1 has 39 digits, so the top digit that can be nonzero is 38
    localparam int TOP_DIGIT   = 38;
    localparam int IDX_W       = $clog2(TOP_DIGIT + 1);
    localparam int STEP_W      = $clog2(VALUE_W);

    // Job queue between front and back
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_AW     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic signed [HALF_W-1:0] value_high;
        logic        [HALF_W-1:0] value_low;
    } t_in_word;

    typedef struct packed {
        logic [NIBBLE_W-1:0] digit;
        logic                last;
    } t_out_word;

    // Classified job: trivial means negative or zero, one digit 0
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               trivial;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

endpackage

@@ rtl/b2d_front.sv @@
module b2d_front
    import b2d_pkg::*;
(
    input  logic     i_in_valid,
    input  t_in_word i_in_word,
    input  logic     i_full,
    output logic     o_in_stall,
    output logic     o_push,
    output t_job     o_job
);

    logic is_neg;
    logic is_zero;

    // Classify the incoming word
    assign is_neg  = i_in_word.value_high[HALF_W-1];
    assign is_zero = (i_in_word.value_low == '0) && (i_in_word.value_high == '0);

    // Accept whenever the queue has room
    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    assign o_job.value   = {i_in_word.value_high, i_in_word.value_low};
    assign o_job.trivial = is_neg || is_zero;

endmodule

@@ rtl/b2d_fifo.sv @@
module b2d_fifo
    import b2d_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic               do_pop;

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/b2d_back.sv @@
module b2d_back
    import b2d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_state                               r_state, n_state;
    logic [DIGIT_COUNT-1:0][NIBBLE_W-1:0] r_bcd, n_bcd;
    logic [VALUE_W-1:0]                   r_val, n_val;
    logic [STEP_W-1:0]                    r_step, n_step;
    logic [IDX_W-1:0]                     r_idx, n_idx;
    logic                                 r_started, n_started;
    logic                                 r_ovalid, n_ovalid;
    t_out_word                            r_oword, n_oword;

    logic [DIGIT_COUNT-1:0][NIBBLE_W-1:0] adj;
    logic [BCD_W-1:0]                     adj_flat;
    logic [NIBBLE_W-1:0]                  cur;
    logic                                 is_last;
    logic                                 out_ok;

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < DIGIT_COUNT; d++) begin
            adj[d] = (r_bcd[d] >= NIBBLE_W'(5)) ? r_bcd[d] + NIBBLE_W'(3) : r_bcd[d];
        end
    end
    assign adj_flat = adj;

    assign cur     = r_bcd[TOP_DIGIT];
    assign is_last = (r_idx == '0);
    assign out_ok  = !r_ovalid || !i_out_stall;

    // Sequence pop, conversion and digit emission
    always_comb begin
        n_state   = r_state;
        n_bcd     = r_bcd;
        n_val     = r_val;
        n_step    = r_step;
        n_idx     = r_idx;
        n_started = r_started;
        n_ovalid  = r_ovalid && i_out_stall;
        n_oword   = r_oword;
        o_pop     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_pop     = 1'b1;
                    n_bcd     = '0;
                    n_started = 1'b0;
                    if (i_job.trivial) begin
                        n_idx   = '0;
                        n_state = ST_EMIT;
                    end else begin
                        n_val   = i_job.value;
                        n_step  = '0;
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                n_bcd  = {adj_flat[BCD_W-2:0], r_val[VALUE_W-1]};
                n_val  = {r_val[VALUE_W-2:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(VALUE_W - 1)) begin
                    n_idx   = IDX_W'(TOP_DIGIT);
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_started && (cur == '0) && !is_last) begin
                    // drop a leading zero
                    n_bcd = {r_bcd[DIGIT_COUNT-2:0], NIBBLE_W'(0)};
                    n_idx = r_idx - 1'b1;
                end else if (out_ok) begin
                    n_ovalid      = 1'b1;
                    n_oword.digit = cur;
                    n_oword.last  = is_last;
                    n_started     = 1'b1;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_bcd = {r_bcd[DIGIT_COUNT-2:0], NIBBLE_W'(0)};
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_idx     <= '0;
            r_started <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_idx     <= n_idx;
            r_started <= n_started;
            r_ovalid  <= n_ovalid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_bcd   <= n_bcd;
        r_val   <= n_val;
        r_oword <= n_oword;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

endmodule

@@ rtl/binary_to_decimal_digits.sv @@
// Channel  Direction  Handshake             Word
// in       input      i_in_valid/o_in_stall  t_in_word  (value_low, value_high)
// out      output     o_out_valid/i_out_stall t_out_word (digit, last)
//
// A positive value is popped from the queue, then takes 128 shift-and-add-3
// steps in the back end, then one digit position per cycle from 38 down to
// 0 unless the output stalls, leading zeros dropped without output.
// A two-word queue lets the input take new words while the back end converts.
// Reset is synchronous, active low; no clearing pass is needed.
// Output stall only holds the emission cycles, conversion keeps running.
module binary_to_decimal_digits
    import b2d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic push;
    logic full;
    logic job_valid;
    logic pop;
    t_job push_job;
    t_job pop_job;

    b2d_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_full     (full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_job      (push_job)
    );

    b2d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (job_valid),
        .i_pop   (pop),
        .o_job   (pop_job)
    );

    b2d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

@@ rtl/b2d_chk.sv @@
module b2d_chk
    import b2d_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_word i_out_word
);

    logic r_first;

    // Track whether the next output word starts a number
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (i_out_valid && !i_out_stall) begin
            r_first <= i_out_word.last;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_word))
        else $error("stalled output word changed");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_word.digit <= NIBBLE_W'(9))
        else $error("output digit above nine");

    a_no_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_first && (i_out_word.digit == '0) |-> i_out_word.last)
        else $error("leading zero emitted");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind binary_to_decimal_digits b2d_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_word  (o_out_word)
);
